/* sv/ihmc_pkg.sv */
// shared constants for the heat-map colour core
// no dependencies
package ihmc_pkg;
	localparam int unsigned RegCount = 7;
	localparam logic [2:0] REG_IMAX = 3'd0;
	localparam logic [2:0] REG_HUE_START = 3'd1;
	localparam logic [2:0] REG_HUE_END = 3'd2;
	localparam logic [2:0] REG_SAT_START = 3'd3;
	localparam logic [2:0] REG_SAT_END = 3'd4;
	localparam logic [2:0] REG_BRI_START = 3'd5;
	localparam logic [2:0] REG_BRI_END = 3'd6;
endpackage

/* sv/ihmc_front.sv */
// front part: clamp and interpolation position, then hue/sat/value lerp
// depends on ihmc_pkg
module ihmc_front #(
	parameter int IB = 16,
	parameter int FB = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [IB-1:0] in_x,
	input logic [IB-1:0] imax,
	input logic [FB:0] hs_a,
	input logic [FB:0] hs_b,
	input logic [FB:0] ss_a,
	input logic [FB:0] ss_b,
	input logic [7:0] bs_a,
	input logic [7:0] bs_b,
	output logic o_valid,
	input logic o_ready,
	output logic [FB:0] o_h,
	output logic [FB:0] o_s,
	output logic [FB+7:0] o_v,
	output logic o_clamp
);
	import ihmc_pkg::*;
	localparam logic [FB:0] One = {1'b1, {FB{1'b0}}};
	localparam int DW = FB + 8;
	localparam int PW = DW + IB;

	// lane 0 hue, lane 1 saturation, lane 2 value
	// stage 0 holds the products, stages 1..DW each do one divide step
	logic en;
	logic vld_q [DW+1];
	logic [IB-1:0] rem_q [DW+1][3];
	logic [DW-1:0] quo_q [DW+1][3];
	logic [2:0] neg_q [DW+1];
	logic [FB:0] ha_q [DW+1];
	logic [FB:0] sa_q [DW+1];
	logic [DW-1:0] va_q [DW+1];
	logic cl_q [DW+1];
	logic [IB-1:0] m_q [DW+1];
	logic ov_q;

	function automatic logic [FB:0] sat1(input logic [FB:0] v);
		return (v > One) ? One : v;
	endfunction

	// restoring step: remainder stays below the divisor, quotient bit shifts in
	function automatic logic [IB+DW-1:0] div_step(input logic [IB-1:0] r,
			input logic [DW-1:0] w, input logic [IB-1:0] d);
		logic [IB:0] t;
		t = {r, w[DW-1]};
		if (t >= {1'b0, d}) return {IB'(t - {1'b0, d}), w[DW-2:0], 1'b1};
		return {t[IB-1:0], w[DW-2:0], 1'b0};
	endfunction

	logic [FB:0] ha, hb, sa, sb;
	logic [DW-1:0] va, vb;
	logic [IB-1:0] x, m1;
	logic cl;
	logic [PW-1:0] prod [3];
	always_comb begin
		m1 = (imax == '0) ? IB'(1) : imax;
		cl = in_x > m1;
		x = cl ? m1 : in_x;
		ha = sat1(hs_a); hb = sat1(hs_b);
		sa = sat1(ss_a); sb = sat1(ss_b);
		va = {bs_a, {FB{1'b0}}}; vb = {bs_b, {FB{1'b0}}};
		// products stay below m * 2^DW, so the top IB bits start below m
		prod[0] = PW'((hb < ha) ? ha - hb : hb - ha) * PW'(x);
		prod[1] = PW'((sb < sa) ? sa - sb : sb - sa) * PW'(x);
		prod[2] = PW'((vb < va) ? va - vb : vb - va) * PW'(x);
	end

	assign en = !ov_q || o_ready;
	assign in_ready = en;
	assign o_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DW; k++) vld_q[k] <= 1'b0;
			ov_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k <= DW; k++) vld_q[k] <= vld_q[k-1];
			ov_q <= vld_q[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rem_q[0][l] <= prod[l][PW-1:DW];
				quo_q[0][l] <= prod[l][DW-1:0];
			end
			neg_q[0] <= {vb < va, sb < sa, hb < ha};
			ha_q[0] <= ha; sa_q[0] <= sa; va_q[0] <= va;
			cl_q[0] <= cl; m_q[0] <= m1;
			for (int k = 1; k <= DW; k++) begin
				for (int l = 0; l < 3; l++)
					{rem_q[k][l], quo_q[k][l]} <= div_step(rem_q[k-1][l],
						quo_q[k-1][l], m_q[k-1]);
				neg_q[k] <= neg_q[k-1];
				ha_q[k] <= ha_q[k-1]; sa_q[k] <= sa_q[k-1]; va_q[k] <= va_q[k-1];
				cl_q[k] <= cl_q[k-1]; m_q[k] <= m_q[k-1];
			end
			if (vld_q[DW]) begin
				o_h <= neg_q[DW][0] ? ha_q[DW] - quo_q[DW][0][FB:0]
					: ha_q[DW] + quo_q[DW][0][FB:0];
				o_s <= neg_q[DW][1] ? sa_q[DW] - quo_q[DW][1][FB:0]
					: sa_q[DW] + quo_q[DW][1][FB:0];
				o_v <= neg_q[DW][2] ? va_q[DW] - quo_q[DW][2] : va_q[DW] + quo_q[DW][2];
				o_clamp <= cl_q[DW];
			end
		end
	end
endmodule

/* sv/ihmc_back.sv */
// back part: six-sector hsv to rgb conversion with output register
// depends on ihmc_pkg
module ihmc_back #(
	parameter int FB = 16
) (
	input logic clk,
	input logic arst_n,
	input logic i_valid,
	output logic i_ready,
	input logic [FB:0] i_h,
	input logic [FB:0] i_s,
	input logic [FB+7:0] i_v,
	input logic i_clamp,
	output logic o_valid,
	input logic o_ready,
	output logic [24:0] o_data
);
	import ihmc_pkg::*;
	localparam logic [FB:0] One = {1'b1, {FB{1'b0}}};
	localparam int VW = FB + 8;

	logic v1_q, v2_q, a1, a2;
	assign a2 = !v2_q || o_ready;
	assign a1 = !v1_q || a2;
	assign i_ready = a1;

	// stage 1: sector, sf, sg
	logic [FB+3:0] h6;
	logic [2:0] sec;
	logic [FB-1:0] f;
	logic [2*FB+1:0] psf, psg;
	always_comb begin
		h6 = (FB+4)'(i_h) * (FB+4)'(6);
		sec = h6[FB+2:FB];
		f = h6[FB-1:0];
		psf = (2*FB+2)'(i_s) * (2*FB+2)'(f);
		psg = (2*FB+2)'(i_s) * (2*FB+2)'(One - {1'b0, f});
	end
	logic [2:0] sec_s1;
	logic [FB:0] s_s1, sf_s1, sg_s1;
	logic [VW-1:0] v_s1;
	logic cl_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v1_q <= 1'b0;
		else if (a1) v1_q <= i_valid;
	end
	always_ff @(posedge clk) begin
		if (a1 && i_valid) begin
			sec_s1 <= sec; s_s1 <= i_s; v_s1 <= i_v; cl_s1 <= i_clamp;
			sf_s1 <= psf[2*FB:FB]; sg_s1 <= psg[2*FB:FB];
		end
	end

	// stage 2: p q t and channel select
	logic [VW+FB:0] pp, pq, pt;
	logic [7:0] p, q, t, vc, r, g, b;
	always_comb begin
		pp = (VW+FB+1)'(v_s1) * (VW+FB+1)'(One - s_s1);
		pq = (VW+FB+1)'(v_s1) * (VW+FB+1)'(One - sf_s1);
		pt = (VW+FB+1)'(v_s1) * (VW+FB+1)'(One - sg_s1);
		p = pp[2*FB+7:2*FB]; q = pq[2*FB+7:2*FB]; t = pt[2*FB+7:2*FB];
		vc = v_s1[VW-1:FB];
		if (s_s1 == '0) begin
			r = vc; g = vc; b = vc;
		end else begin
			case (sec_s1)
				3'd1: begin r = q; g = vc; b = p; end
				3'd2: begin r = p; g = vc; b = t; end
				3'd3: begin r = p; g = q; b = vc; end
				3'd4: begin r = t; g = p; b = vc; end
				3'd5: begin r = vc; g = p; b = q; end
				default: begin r = vc; g = t; b = p; end
			endcase
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v2_q <= 1'b0;
		else if (a2) v2_q <= v1_q;
	end
	always_ff @(posedge clk) begin
		if (a2 && v1_q) o_data <= {cl_s1, b, g, r};
	end
	assign o_valid = v2_q;
endmodule

/* sv/ihmc_fifo.sv */
// two-entry queue between front and back parts
// depends on ihmc_pkg
module ihmc_fifo #(
	parameter int W = 8
) (
	input logic clk,
	input logic arst_n,
	input logic i_valid,
	output logic i_ready,
	input logic [W-1:0] i_data,
	output logic o_valid,
	input logic o_ready,
	output logic [W-1:0] o_data
);
	import ihmc_pkg::*;
	logic [W-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;
	assign i_ready = cnt_q != 2'd2;
	assign o_valid = cnt_q != 2'd0;
	assign wr = i_valid && i_ready;
	assign rd = o_valid && o_ready;
	assign o_data = mem_q[rp_q];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= i_data;
	end
endmodule

/* sv/intensity_heat_map_colour_core.sv */
// heat-map colour core: an input transfer passes the front (product register,
// FRACTION_BITS+8 divide steps, sum register), then a queue write, then the
// 2 back stages; throughput one item per clock while no stage stalls, and the queue lets
// front and back stall on their own
// reset clears all valid flags and loads the yellow to red gradient
module intensity_heat_map_colour_core #(
	parameter int INTENSITY_BITS = 16,
	parameter int FRACTION_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [((INTENSITY_BITS+7)/8)*8-1:0] s_axis_tdata, // intensity
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // red, green, blue, clamped
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ihmc_pkg::*;
	localparam int IB = INTENSITY_BITS;
	localparam int FB = FRACTION_BITS;
	localparam int QW = 3*FB + 11;

	logic [IB-1:0] imax_q;
	logic [FB:0] hs_q, he_q, ss_q, se_q;
	logic [7:0] bs_q, be_q;
	logic [2:0] ridx;
	assign ridx = paddr[4:2];
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imax_q <= '1;
			hs_q <= (FB+1)'((64'd1 << FB) / 64'd6 + 64'd1);
			he_q <= '0;
			ss_q <= {1'b1, {FB{1'b0}}};
			se_q <= {1'b1, {FB{1'b0}}};
			bs_q <= 8'hff; be_q <= 8'hff;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_IMAX: imax_q <= pwdata[IB-1:0];
				REG_HUE_START: hs_q <= pwdata[FB:0];
				REG_HUE_END: he_q <= pwdata[FB:0];
				REG_SAT_START: ss_q <= pwdata[FB:0];
				REG_SAT_END: se_q <= pwdata[FB:0];
				REG_BRI_START: bs_q <= pwdata[7:0];
				REG_BRI_END: be_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (ridx)
			REG_IMAX: prdata = 32'(imax_q);
			REG_HUE_START: prdata = 32'(hs_q);
			REG_HUE_END: prdata = 32'(he_q);
			REG_SAT_START: prdata = 32'(ss_q);
			REG_SAT_END: prdata = 32'(se_q);
			REG_BRI_START: prdata = 32'(bs_q);
			REG_BRI_END: prdata = 32'(be_q);
			default: prdata = '0;
		endcase
	end

	logic fv, fr, bv, br;
	logic [FB:0] fh, fs;
	logic [FB+7:0] fvv;
	logic fc;
	logic [QW-1:0] qd;
	logic [24:0] od;

	ihmc_front #(.IB(IB), .FB(FB)) u_front (
		.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_x(s_axis_tdata[IB-1:0]), .imax(imax_q), .hs_a(hs_q), .hs_b(he_q),
		.ss_a(ss_q), .ss_b(se_q), .bs_a(bs_q), .bs_b(be_q),
		.o_valid(fv), .o_ready(fr), .o_h(fh), .o_s(fs), .o_v(fvv), .o_clamp(fc)
	);
	ihmc_fifo #(.W(QW)) u_fifo (
		.clk, .arst_n, .i_valid(fv), .i_ready(fr), .i_data({fc, fvv, fs, fh}),
		.o_valid(bv), .o_ready(br), .o_data(qd)
	);
	ihmc_back #(.FB(FB)) u_back (
		.clk, .arst_n, .i_valid(bv), .i_ready(br),
		.i_h(qd[FB:0]), .i_s(qd[2*FB+1:FB+1]), .i_v(qd[3*FB+9:2*FB+2]),
		.i_clamp(qd[QW-1]),
		.o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_data(od)
	);
	assign m_axis_tdata = {7'd0, od};

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[31:25] == 7'd0)
		else $error("padding bits not zero");
`endif
endmodule

/* tb/testbench.sv */
// self-checking testbench for the heat-map colour core
// depends on ihmc_pkg and intensity_heat_map_colour_core
`timescale 1ns / 100ps

module testbench;
	import ihmc_pkg::*;

	localparam int FB = 16;
	localparam logic [63:0] ONE = 64'd1 << FB;
	localparam int LIMIT = 5000;

	typedef struct packed {
		logic clamped;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} colour_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0; // intensity
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [31:0] m_axis_tdata; // red, green, blue, clamped
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	intensity_heat_map_colour_core dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// shadow copy of the gradient registers
	logic [63:0] imax, hue_a, hue_b, sat_a, sat_b, bri_a, bri_b;
	logic [15:0] sample_q[$];
	colour_t colour_q[$];
	int errors = 0;
	int send_idle = 0, recv_idle = 0;
	int quiet = 0;
	logic taken = 0;

	function automatic logic [63:0] lerp(logic [63:0] a, logic [63:0] b,
			logic [63:0] x, logic [63:0] m);
		if (b >= a) return a + ((b - a) * x) / m;
		return a - ((a - b) * x) / m;
	endfunction

	function automatic logic [63:0] cap(logic [63:0] v);
		return v > ONE ? ONE : v;
	endfunction

	function automatic colour_t heat_colour(logic [15:0] sample);
		logic [63:0] m, x, h, s, v, vc, h6, sec, f, sf, sg, p, q, t;
		colour_t c;
		m = imax == 0 ? 64'd1 : imax;
		x = 64'(sample);
		c.clamped = x > m;
		if (x > m) x = m;
		h = lerp(cap(hue_a), cap(hue_b), x, m);
		s = lerp(cap(sat_a), cap(sat_b), x, m);
		v = lerp(bri_a << FB, bri_b << FB, x, m);
		vc = v >> FB;
		h6 = h * 6;
		sec = h6 >> FB;
		f = h6 & (ONE - 1);
		sf = (s * f) >> FB;
		sg = (s * (ONE - f)) >> FB;
		p = ((v * (ONE - s)) >> FB) >> FB;
		q = ((v * (ONE - sf)) >> FB) >> FB;
		t = ((v * (ONE - sg)) >> FB) >> FB;
		if (s == 0) {c.red, c.green, c.blue} = {vc[7:0], vc[7:0], vc[7:0]};
		else case (sec)
			1: {c.red, c.green, c.blue} = {q[7:0], vc[7:0], p[7:0]};
			2: {c.red, c.green, c.blue} = {p[7:0], vc[7:0], t[7:0]};
			3: {c.red, c.green, c.blue} = {p[7:0], q[7:0], vc[7:0]};
			4: {c.red, c.green, c.blue} = {t[7:0], p[7:0], vc[7:0]};
			5: {c.red, c.green, c.blue} = {vc[7:0], p[7:0], q[7:0]};
			default: {c.red, c.green, c.blue} = {vc[7:0], t[7:0], p[7:0]};
		endcase
		return c;
	endfunction

	// driver: predicts at the transfer so config changes stay in order
	always @(posedge clk) begin
		taken = s_axis_tvalid && s_axis_tready;
		if (taken) begin
			colour_q.push_back(heat_colour(s_axis_tdata));
			void'(sample_q.pop_front());
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			// a waiting transfer keeps tvalid and tdata
			if (!s_axis_tvalid || taken) begin
				if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					s_axis_tvalid <= 1;
					s_axis_tdata <= sample_q[0];
				end else
					s_axis_tvalid <= 0;
			end
			m_axis_tready <= $urandom_range(99) >= recv_idle;
		end
	end

	// monitor
	always @(posedge clk) begin
		colour_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[24:0];
			if (colour_q.size() == 0) begin
				$display("%0t: result with none pending, actual %h", $time, got);
				errors++;
			end else begin
				want = colour_q.pop_front();
				if (got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue || got.clamped !== want.clamped
						|| m_axis_tdata[31:25] !== '0) begin
					$display("%0t: mismatch expected %h actual %h", $time, want,
						m_axis_tdata);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_IMAX: imax = 64'(val[15:0]);
			REG_HUE_START: hue_a = 64'(val[16:0]);
			REG_HUE_END: hue_b = 64'(val[16:0]);
			REG_SAT_START: sat_a = 64'(val[16:0]);
			REG_SAT_END: sat_b = 64'(val[16:0]);
			REG_BRI_START: bri_a = 64'(val[7:0]);
			REG_BRI_END: bri_b = 64'(val[7:0]);
			default: ;
		endcase
	endtask

	task automatic drain;
		wait (sample_q.size() == 0 && colour_q.size() == 0);
		repeat (10) @(negedge clk);
	endtask

	task automatic gradient(logic [15:0] mx, logic [16:0] h0, logic [16:0] h1,
			logic [16:0] s0, logic [16:0] s1, logic [7:0] b0, logic [7:0] b1);
		reg_write(REG_IMAX, 32'(mx));
		reg_write(REG_HUE_START, 32'(h0));
		reg_write(REG_HUE_END, 32'(h1));
		reg_write(REG_SAT_START, 32'(s0));
		reg_write(REG_SAT_END, 32'(s1));
		reg_write(REG_BRI_START, 32'(b0));
		reg_write(REG_BRI_END, 32'(b1));
	endtask

	task automatic random_samples(int n, logic [15:0] mx);
		repeat (n) begin
			case ($urandom_range(3))
				0: sample_q.push_back(16'($urandom));
				1: sample_q.push_back(16'($urandom_range(32'(mx))));
				2: sample_q.push_back(16'(32'(mx) + $urandom_range(1) - $urandom_range(1)));
				default: sample_q.push_back($urandom_range(3) ? 16'hffff : 16'h0);
			endcase
		end
	endtask

	task automatic random_gradient(output logic [15:0] mx);
		mx = 16'($urandom_range(2) == 0 ? $urandom_range(8) : $urandom);
		gradient(mx,
			17'($urandom_range(2) ? $urandom_range(65536) : $urandom_range(131071)),
			17'($urandom_range(2) ? $urandom_range(65536) : $urandom_range(131071)),
			17'($urandom_range(3) ? $urandom_range(65536) : $urandom_range(1) << 16),
			17'($urandom_range(3) ? $urandom_range(65536) : $urandom_range(131071)),
			8'($urandom), 8'($urandom));
	endtask

	initial begin
		logic [15:0] mx;
		imax = 64'hffff; hue_a = 64'd10923; hue_b = 64'd0;
		sat_a = ONE; sat_b = ONE; bri_a = 64'd255; bri_b = 64'd255;
		repeat (9) @(negedge clk);
		arst_n = 1;

		// reset gradient, extremes of the intensity
		send_idle = 10; recv_idle = 88;
		sample_q.push_back(16'h0); sample_q.push_back(16'h1);
		sample_q.push_back(16'h5555); sample_q.push_back(16'haaaa);
		sample_q.push_back(16'hfffe); sample_q.push_back(16'hffff);
		drain();
		// zero maximum, clamping, oversized hue and saturation, grey, sector six
		gradient(16'd0, 17'h1ffff, 17'h10000, 17'd0, 17'd0, 8'd255, 8'd0);
		sample_q.push_back(16'd0); sample_q.push_back(16'd1);
		sample_q.push_back(16'hffff);
		drain();
		gradient(16'd100, 17'h10000, 17'h10000, 17'h1ffff, 17'h10000, 8'd0, 8'd255);
		sample_q.push_back(16'd0); sample_q.push_back(16'd50);
		sample_q.push_back(16'd100); sample_q.push_back(16'd101);
		sample_q.push_back(16'hffff);
		drain();
		// walk every sector
		gradient(16'hffff, 17'd0, 17'h10000, 17'h10000, 17'h08000, 8'd255, 8'd128);
		for (int i = 0; i < 8; i++) sample_q.push_back(16'(i * 9362));
		drain();

		for (int ph = 0; ph < 18; ph++) begin
			if (ph == 6) begin send_idle = 88; recv_idle = 10; end
			if (ph == 12) begin send_idle = 0; recv_idle = 0; end
			random_gradient(mx);
			random_samples(90, mx);
			drain();
		end

		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
